[src/slink_pkg.sv]
// ----------------------------------------------------------------------------
// slink_pkg
// Shared types and codes of the sensor packet link: request functions,
// result kinds, register indexes, output slot positions and job descriptor.
// ----------------------------------------------------------------------------
package slink_pkg;

   // request function codes (value 3 is unused)
   localparam logic [1:0] FUNC_PAYLOAD = 2'd0;
   localparam logic [1:0] FUNC_RX_BYTE = 2'd1;
   localparam logic [1:0] FUNC_TICK    = 2'd2;

   typedef enum logic [1:0] {
      KIND_TX      = 2'd0,
      KIND_RX_DATA = 2'd1,
      KIND_DONE    = 2'd2,
      KIND_TIMEOUT = 2'd3
   } kind_type;

   // register indexes
   localparam int         CSR_INDEX_W           = 3;
   localparam logic [2:0] CSR_DEVICE_ADDRESS    = 3'd0;
   localparam logic [2:0] CSR_SYNC_WORD         = 3'd1;
   localparam logic [2:0] CSR_COMMAND_ID        = 3'd2;
   localparam logic [2:0] CSR_ACK_ID            = 3'd3;
   localparam logic [2:0] CSR_TIMEOUT_EVENTS    = 3'd4;

   localparam logic [31:0] RST_DEVICE_ADDRESS   = 32'hFFFF_FFFF;
   localparam logic [15:0] RST_SYNC_WORD        = 16'hEF01;
   localparam logic [7:0]  RST_COMMAND_ID       = 8'd1;
   localparam logic [7:0]  RST_ACK_ID           = 8'd7;
   localparam logic [15:0] RST_TIMEOUT_EVENTS   = 16'd1000;

   // output slots of a job, emitted lowest first
   localparam int SLOT_COUNT   = 15;
   localparam int SLOT_W       = 4;
   localparam int SLOT_HDR0    = 0;   // start code high .. length low: 0..8
   localparam int SLOT_HDR_LAST = 8;
   localparam int SLOT_PAYLOAD = 9;
   localparam int SLOT_CKS_HI  = 10;
   localparam int SLOT_CKS_LO  = 11;
   localparam int SLOT_RX_DATA = 12;
   localparam int SLOT_DONE    = 13;
   localparam int SLOT_TIMEOUT = 14;

   localparam logic [SLOT_W-1:0] S_START_HI = 4'd0;
   localparam logic [SLOT_W-1:0] S_START_LO = 4'd1;
   localparam logic [SLOT_W-1:0] S_ADDR3    = 4'd2;
   localparam logic [SLOT_W-1:0] S_ADDR2    = 4'd3;
   localparam logic [SLOT_W-1:0] S_ADDR1    = 4'd4;
   localparam logic [SLOT_W-1:0] S_ADDR0    = 4'd5;
   localparam logic [SLOT_W-1:0] S_CMD_ID   = 4'd6;
   localparam logic [SLOT_W-1:0] S_LEN_HI   = 4'd7;
   localparam logic [SLOT_W-1:0] S_LEN_LO   = 4'd8;
   localparam logic [SLOT_W-1:0] S_PAYLOAD  = 4'd9;
   localparam logic [SLOT_W-1:0] S_CKS_HI   = 4'd10;
   localparam logic [SLOT_W-1:0] S_CKS_LO   = 4'd11;
   localparam logic [SLOT_W-1:0] S_RX_DATA  = 4'd12;
   localparam logic [SLOT_W-1:0] S_DONE     = 4'd13;
   localparam logic [SLOT_W-1:0] S_TIMEOUT  = 4'd14;

   typedef struct packed {
      logic [31:0] device_address;
      logic [15:0] sync_word;
      logic [7:0]  command_id;
      logic [7:0]  ack_id;
      logic [15:0] timeout_events;
   } cfg_type;

   // one classified request: which slots to emit and their variable bytes
   typedef struct packed {
      logic [SLOT_COUNT-1:0] slots;
      logic [15:0]           len;
      logic [7:0]            pay;
      logic [15:0]           cks;
      logic [7:0]            rx_byte;
      logic [7:0]            code;
   } job_type;

endpackage

[src/slink_if.sv]
// ----------------------------------------------------------------------------
// slink_req_if / slink_rsp_if
// Valid/ready channels of the sensor packet link.
// ----------------------------------------------------------------------------
interface slink_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  data_byte;
   logic [15:0] payload_length;
   logic        last_byte;

   modport source (output valid, func, data_byte, payload_length, last_byte,
                   input ready);
   modport sink   (input valid, func, data_byte, payload_length, last_byte,
                   output ready);
endinterface

interface slink_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic       run_last;

   modport source (output valid, kind, out_byte, run_last, input ready);
   modport sink   (input valid, kind, out_byte, run_last, output ready);
endinterface

[src/sensor_packet_link.sv]
// ----------------------------------------------------------------------------
// sensor_packet_link
// Command/response packet engine for a serial sensor link: builds command
// packets (header, payload, checksum) and parses reply packets.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  req_chan  in   valid/ready        func, data_byte, payload_length, last_byte
//  rsp_chan  out  valid/ready        kind, out_byte, run_last
//  csr_*     in   csr_wr_en          csr_index (3), csr_wdata (32), no read-back
//
//  A request is taken when the job queue has room; its results leave one per
//  cycle while rsp_chan is ready, up to 12 results for the first payload
//  byte of a command (9 header + payload + 2 checksum), otherwise 1 to 3. The
//  result emitter in the back end sets the rate; no-result requests push no job.
//  Reset is synchronous, active high; registers return to their reset values
//  at once, no clearing pass. A stalled rsp_chan fills the queue, then
//  req_chan.ready drops; until then the front keeps taking requests.
// ----------------------------------------------------------------------------
module sensor_packet_link import slink_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   slink_req_if.sink              req_chan,
   slink_rsp_if.source            rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   logic    q_full;
   logic    q_push;
   job_type push_job;
   logic    q_pop;
   logic    q_valid;
   job_type q_job;

   // register file: user writes it only while the link is quiet; not enforced
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS: cfg_in.device_address = csr_wdata;
            CSR_SYNC_WORD:      cfg_in.sync_word      = csr_wdata[15:0];
            CSR_COMMAND_ID:     cfg_in.command_id     = csr_wdata[7:0];
            CSR_ACK_ID:         cfg_in.ack_id         = csr_wdata[7:0];
            CSR_TIMEOUT_EVENTS: cfg_in.timeout_events = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= RST_DEVICE_ADDRESS;
         cfg_ff.sync_word      <= RST_SYNC_WORD;
         cfg_ff.command_id     <= RST_COMMAND_ID;
         cfg_ff.ack_id         <= RST_ACK_ID;
         cfg_ff.timeout_events <= RST_TIMEOUT_EVENTS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: classify request, update packet state, push a job
   slink_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req    (req_chan),
      .q_full (q_full),
      .push   (q_push),
      .job    (push_job)
   );

   // decoupling queue
   slink_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .q_valid  (q_valid),
      .q_job    (q_job)
   );

   // back: one result transfer per cycle from the head job while rsp_chan is ready
   slink_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_job   (q_job),
      .pop     (q_pop),
      .rsp     (rsp_chan)
   );

endmodule

[src/slink_front.sv]
// ----------------------------------------------------------------------------
// slink_front
// Accepts requests, runs the packet state (tx checksum, rx header matcher,
// timeout count) and pushes one job per request that yields results.
// ----------------------------------------------------------------------------
module slink_front import slink_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   slink_req_if.sink      req,
   input  logic           q_full,
   output logic           push,
   output job_type        job
);

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_TX   = 2'd1,
      PH_RX   = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] cks_ff, cks_in;
   logic [16:0] pos_ff, pos_in;
   logic [15:0] rlen_ff, rlen_in;
   logic [15:0] evt_ff, evt_in;
   logic [7:0]  code_ff, code_in;

   logic        accept;
   logic        do_count;
   logic [15:0] len;
   logic [15:0] cks_base;
   logic [15:0] evt_next;
   logic [16:0] pos_rel;
   logic [7:0]  b;
   logic [7:0]  addr_byte;
   logic [7:0]  code_now;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign b         = req.data_byte;
   assign len       = req.payload_length + 16'd2;
   assign evt_next  = evt_ff + 16'd1;
   assign pos_rel   = pos_ff - 17'd8;

   always_comb begin
      case (pos_ff[2:0])
         3'd2:    addr_byte = cfg.device_address[31:24];
         3'd3:    addr_byte = cfg.device_address[23:16];
         3'd4:    addr_byte = cfg.device_address[15:8];
         default: addr_byte = cfg.device_address[7:0];
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      cks_in   = cks_ff;
      pos_in   = pos_ff;
      rlen_in  = rlen_ff;
      evt_in   = evt_ff;
      code_in  = code_ff;
      job      = '0;
      do_count = 1'b0;
      code_now = code_ff;
      cks_base = cks_ff;
      job.len  = len;
      job.pay  = b;
      job.rx_byte = b;

      if (accept) begin
         case (req.func)
            FUNC_PAYLOAD: begin
               if (phase_ff != PH_TX) begin
                  job.slots[SLOT_HDR_LAST:SLOT_HDR0] = '1;
                  cks_base = {8'd0, len[15:8]} + {8'd0, len[7:0]}
                             + {8'd0, cfg.command_id};
               end
               job.slots[SLOT_PAYLOAD] = 1'b1;
               cks_in   = cks_base + {8'd0, b};
               job.cks  = cks_in;
               phase_in = PH_TX;
               if (req.last_byte) begin
                  job.slots[SLOT_CKS_HI] = 1'b1;
                  job.slots[SLOT_CKS_LO] = 1'b1;
                  phase_in = PH_RX;
                  pos_in   = '0;
                  rlen_in  = '0;
                  evt_in   = '0;
               end
            end
            FUNC_RX_BYTE: begin
               if (phase_ff == PH_RX) begin
                  do_count = 1'b1;
                  if (pos_ff == 17'd0) begin
                     if (b == cfg.sync_word[15:8]) pos_in = 17'd1;
                  end else if (pos_ff == 17'd1) begin
                     pos_in = (b == cfg.sync_word[7:0]) ? 17'd2 : 17'd0;
                  end else if (pos_ff <= 17'd5) begin
                     pos_in = (b == addr_byte) ? pos_ff + 17'd1 : 17'd0;
                  end else if (pos_ff == 17'd6) begin
                     pos_in = (b == cfg.ack_id) ? 17'd7 : 17'd0;
                  end else if (pos_ff == 17'd7) begin
                     rlen_in = {b, 8'd0};
                     pos_in  = 17'd8;
                  end else if (pos_ff == 17'd8) begin
                     rlen_in = {rlen_ff[15:8], b};
                     pos_in  = 17'd9;
                  end else begin
                     job.slots[SLOT_RX_DATA] = 1'b1;
                     if (pos_ff == 17'd9) code_now = b;
                     code_in  = code_now;
                     job.code = code_now;
                     if (pos_rel == {1'b0, rlen_ff}) begin
                        job.slots[SLOT_DONE] = 1'b1;
                        phase_in = PH_IDLE;
                        do_count = 1'b0;
                     end else if (pos_ff != 17'h1FFFF) begin
                        pos_in = pos_ff + 17'd1;
                     end
                  end
               end
            end
            FUNC_TICK: begin
               if (phase_ff == PH_RX) do_count = 1'b1;
            end
            default: begin
            end
         endcase

         if (do_count) begin
            evt_in = evt_next;
            if (evt_next >= cfg.timeout_events || cfg.timeout_events == 16'd0) begin
               job.slots[SLOT_TIMEOUT] = 1'b1;
               phase_in = PH_IDLE;
            end
         end
      end
   end

   assign push = accept && (job.slots != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cks_ff   <= '0;
         pos_ff   <= '0;
         rlen_ff  <= '0;
         evt_ff   <= '0;
         code_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         cks_ff   <= cks_in;
         pos_ff   <= pos_in;
         rlen_ff  <= rlen_in;
         evt_ff   <= evt_in;
         code_ff  <= code_in;
      end
   end

endmodule

[src/slink_queue.sv]
// ----------------------------------------------------------------------------
// slink_queue
// Small job queue between front and back.
// ----------------------------------------------------------------------------
module slink_queue import slink_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    q_valid,
   output job_type q_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == CNT_FULL);
   assign q_valid = (count_ff != '0);
   assign q_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop)) else $error("job queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !q_valid)) else $error("job queue underflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL) else $error("job queue count out of range");
`endif

endmodule

[src/slink_back.sv]
// ----------------------------------------------------------------------------
// slink_back
// Expands queued jobs into result transfers, one slot per cycle while rsp is
// ready, through a registered output stage.
// ----------------------------------------------------------------------------
module slink_back import slink_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           q_valid,
   input  job_type        q_job,
   output logic           pop,
   slink_rsp_if.source    rsp
);

   job_type               job_ff, job_in;
   logic [SLOT_COUNT-1:0] rem_ff, rem_in;
   logic                  valid_ff, valid_in;
   kind_type              kind_ff, kind_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  last_ff, last_in;

   logic                  advance;
   logic                  from_q;
   job_type               cur_job;
   logic [SLOT_COUNT-1:0] cur_mask;
   logic [SLOT_COUNT-1:0] low_bit;
   logic [SLOT_W-1:0]     slot;

   assign advance  = !valid_ff || rsp.ready;
   assign from_q   = (rem_ff == '0) && q_valid;
   assign cur_job  = from_q ? q_job : job_ff;
   assign cur_mask = from_q ? q_job.slots : rem_ff;
   assign low_bit  = cur_mask & (~cur_mask + 1'b1);
   assign pop      = advance && from_q;

   always_comb begin
      slot = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (low_bit[i]) slot = slot | SLOT_W'(i);
      end
   end

   always_comb begin
      job_in   = job_ff;
      rem_in   = rem_ff;
      valid_in = valid_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = (cur_mask != '0);
         job_in   = cur_job;
         rem_in   = cur_mask & ~low_bit;
         last_in  = ((cur_mask & ~low_bit) == '0);
         kind_in  = KIND_TX;
         case (slot)
            S_START_HI: byte_in = cfg.sync_word[15:8];
            S_START_LO: byte_in = cfg.sync_word[7:0];
            S_ADDR3:    byte_in = cfg.device_address[31:24];
            S_ADDR2:    byte_in = cfg.device_address[23:16];
            S_ADDR1:    byte_in = cfg.device_address[15:8];
            S_ADDR0:    byte_in = cfg.device_address[7:0];
            S_CMD_ID:   byte_in = cfg.command_id;
            S_LEN_HI:   byte_in = cur_job.len[15:8];
            S_LEN_LO:   byte_in = cur_job.len[7:0];
            S_PAYLOAD:  byte_in = cur_job.pay;
            S_CKS_HI:   byte_in = cur_job.cks[15:8];
            S_CKS_LO:   byte_in = cur_job.cks[7:0];
            S_RX_DATA: begin
               kind_in = KIND_RX_DATA;
               byte_in = cur_job.rx_byte;
            end
            S_DONE: begin
               kind_in = KIND_DONE;
               byte_in = cur_job.code;
            end
            S_TIMEOUT: begin
               kind_in = KIND_TIMEOUT;
               byte_in = 8'd0;
            end
            default: byte_in = 8'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         rem_ff   <= rem_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp.valid    = valid_ff;
   assign rsp.kind     = kind_ff;
   assign rsp.out_byte = byte_ff;
   assign rsp.run_last = last_ff;

`ifndef SYNTHESIS
   a_timeout_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == KIND_TIMEOUT |-> last_ff)
      else $error("timeout result not marked last");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == KIND_DONE |-> last_ff)
      else $error("completion result not marked last");
   a_rem_shown: assert property (@(posedge clock) disable iff (reset)
      rem_ff != '0 |-> valid_ff && !last_ff)
      else $error("pending slots without a shown non-final result");
`endif

endmodule
